// File: hdl/glh_pkg.sv
package glh_pkg;

    localparam int BOUND_W = 16;
    localparam int GAP_W   = 4;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [BOUND_W-1:0] LOWER_BOUND_RST = 16'd19661;
    localparam logic [BOUND_W-1:0] UPPER_BOUND_RST = 16'd39322;
    localparam logic [GAP_W-1:0]   MAX_GAP_RST     = 4'd10;
    localparam logic [CNT_W-1:0]   GAP_LIMIT_RST   = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_BOUND = 2'd0,
        CFG_UPPER_BOUND = 2'd1,
        CFG_MAX_GAP     = 2'd2,
        CFG_GAP_LIMIT   = 2'd3
    } t_cfg_index;

    // one classified sample handed from front to back
    typedef struct packed {
        logic             inc;
        logic [GAP_W-1:0] bin;
        logic             report;
        logic [GAP_W-1:0] top;
        logic [CNT_W-1:0] gaps;
    } t_gap_op;

endpackage

// File: hdl/glh_front.sv
module glh_front import glh_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int BIN_COUNT   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last_of_stream,
    input  logic                   i_push_ready,
    input  logic [BOUND_W-1:0]     i_lower_bound,
    input  logic [BOUND_W-1:0]     i_upper_bound,
    input  logic [GAP_W-1:0]       i_max_gap,
    input  logic [CNT_W-1:0]       i_gap_limit,
    output logic                   o_push_valid,
    output t_gap_op                o_push_op
);

    localparam int CMP_W = (SAMPLE_BITS > BOUND_W) ? SAMPLE_BITS : BOUND_W;
    localparam logic [GAP_W-1:0] RUN_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [GAP_W-1:0] r_run;
    logic [GAP_W-1:0] n_run;
    logic [CNT_W-1:0] r_gaps;
    logic [CNT_W-1:0] n_gaps;

    logic             hit;
    logic             active;
    logic             transfer;
    logic [GAP_W-1:0] top;
    logic [GAP_W-1:0] bin;

    assign transfer = i_valid && i_push_ready;
    assign hit = (CMP_W'(i_sample) >= CMP_W'(i_lower_bound)) &&
                 (CMP_W'(i_sample) <  CMP_W'(i_upper_bound));
    assign active = r_gaps < i_gap_limit;
    assign top = (32'(i_max_gap) > BIN_COUNT - 1) ? GAP_W'(BIN_COUNT - 1) : i_max_gap;
    assign bin = (r_run < top) ? r_run : top;

    always_comb begin
        n_run  = r_run;
        n_gaps = r_gaps;
        if (active) begin
            if (hit) begin
                n_run = '0;
                if (r_gaps != CNT_MAX) begin
                    n_gaps = r_gaps + 1'b1;
                end
            end else if (r_run != RUN_MAX) begin
                n_run = r_run + 1'b1;
            end
        end
    end

    always_comb begin
        o_push_valid     = i_valid;
        o_push_op.inc    = active && hit;
        o_push_op.bin    = bin;
        o_push_op.report = i_last_of_stream;
        o_push_op.top    = top;
        o_push_op.gaps   = n_gaps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_gaps <= '0;
        end else if (transfer) begin
            if (i_last_of_stream) begin
                r_run  <= '0;
                r_gaps <= '0;
            end else begin
                r_run  <= n_run;
                r_gaps <= n_gaps;
            end
        end
    end

endmodule

// File: hdl/glh_queue.sv
module glh_queue import glh_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    input  t_gap_op i_push_op,
    output logic    o_push_ready,
    output logic    o_pop_valid,
    output t_gap_op o_pop_op,
    input  logic    i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_gap_op            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != CNT_W_Q'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/glh_back.sv
module glh_back import glh_pkg::*; #(
    parameter int BIN_COUNT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    input  t_gap_op          i_pop_op,
    output logic             o_pop_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [GAP_W-1:0] o_bin_index,
    output logic [CNT_W-1:0] o_bin_count,
    output logic [CNT_W-1:0] o_gaps_total,
    output logic             o_last
);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic {
        S_IDLE,
        S_REPORT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_bin [BIN_COUNT];
    logic [GAP_W-1:0] r_idx;
    logic [GAP_W-1:0] r_top;
    logic [CNT_W-1:0] r_gaps;
    logic             r_out_valid;
    logic [GAP_W-1:0] r_out_bin_index;
    logic [CNT_W-1:0] r_out_bin_count;
    logic [CNT_W-1:0] r_out_gaps_total;
    logic             r_out_last;

    logic pop;
    logic out_free;
    logic emit;
    logic emit_last;

    assign o_pop_ready = r_state == S_IDLE;
    assign pop         = i_pop_valid && o_pop_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign emit        = (r_state == S_REPORT) && out_free;
    assign emit_last   = r_idx == r_top;

    assign o_valid      = r_out_valid;
    assign o_bin_index  = r_out_bin_index;
    assign o_bin_count  = r_out_bin_count;
    assign o_gaps_total = r_out_gaps_total;
    assign o_last       = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            for (int i = 0; i < BIN_COUNT; i++) begin
                r_bin[i] <= '0;
            end
        end else begin
            if (out_free) begin
                r_out_valid <= r_state == S_REPORT;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        for (int i = 0; i < BIN_COUNT; i++) begin
                            if (i_pop_op.inc && (32'(i_pop_op.bin) == i) &&
                                (r_bin[i] != CNT_MAX)) begin
                                r_bin[i] <= r_bin[i] + 1'b1;
                            end
                        end
                        if (i_pop_op.report) begin
                            r_state <= S_REPORT;
                            r_idx   <= '0;
                            r_top   <= i_pop_op.top;
                            r_gaps  <= i_pop_op.gaps;
                        end
                    end
                end
                S_REPORT: begin
                    if (emit) begin
                        r_out_bin_index  <= r_idx;
                        r_out_bin_count  <= r_bin[0];
                        r_out_gaps_total <= r_gaps;
                        r_out_last       <= emit_last;
                        r_idx            <= r_idx + 1'b1;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                            for (int i = 0; i < BIN_COUNT; i++) begin
                                r_bin[i] <= '0;
                            end
                        end else begin
                            // shift the next bin down to the read position
                            for (int i = 0; i < BIN_COUNT - 1; i++) begin
                                r_bin[i] <= r_bin[i+1];
                            end
                            r_bin[BIN_COUNT-1] <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/gap_length_histogram.sv
// Streaming gap-length histogram. One sample transfer is taken per clock while
// o_ready is high: the front stage tests lower_bound <= sample < upper_bound,
// tracks the miss run and the gap total, and hands a bin update to the back
// stage through a four-entry queue; the back stage applies one bin update per
// clock while no report is running. A sample flagged last_of_stream starts a
// report of min(max_gap, BIN_COUNT-1)+1 result transfers, one per clock while
// the output is taken, each carrying the bin, its count and the gap total; the
// final one has o_last set. From the transfer that starts a report until its
// last result is loaded, the back stage takes no update, so samples queue up
// and o_ready drops once the queue is full. The histogram, run and gap total
// are cleared after each report. Configuration registers are to be written
// only while no sample or report is in flight.
module gap_length_histogram import glh_pkg::*; #(
    parameter int BIN_COUNT   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [BOUND_W-1:0]     i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_last_of_stream,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [GAP_W-1:0]       o_bin_index,
    output logic [CNT_W-1:0]       o_bin_count,
    output logic [CNT_W-1:0]       o_gaps_total,
    output logic                   o_last
);

    logic [BOUND_W-1:0] r_lower_bound;
    logic [BOUND_W-1:0] r_upper_bound;
    logic [GAP_W-1:0]   r_max_gap;
    logic [CNT_W-1:0]   r_gap_limit;

    logic    push_valid;
    logic    push_ready;
    t_gap_op push_op;
    logic    pop_valid;
    logic    pop_ready;
    t_gap_op pop_op;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= LOWER_BOUND_RST;
            r_upper_bound <= UPPER_BOUND_RST;
            r_max_gap     <= MAX_GAP_RST;
            r_gap_limit   <= GAP_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LOWER_BOUND: r_lower_bound <= i_cfg_data;
                CFG_UPPER_BOUND: r_upper_bound <= i_cfg_data;
                CFG_MAX_GAP:     r_max_gap     <= i_cfg_data[GAP_W-1:0];
                CFG_GAP_LIMIT:   r_gap_limit   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    glh_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .BIN_COUNT   (BIN_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_sample         (i_sample),
        .i_last_of_stream (i_last_of_stream),
        .i_push_ready     (push_ready),
        .i_lower_bound    (r_lower_bound),
        .i_upper_bound    (r_upper_bound),
        .i_max_gap        (r_max_gap),
        .i_gap_limit      (r_gap_limit),
        .o_push_valid     (push_valid),
        .o_push_op        (push_op)
    );

    glh_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_op    (push_op),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_op     (pop_op),
        .i_pop_ready  (pop_ready)
    );

    glh_back #(
        .BIN_COUNT (BIN_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .i_pop_op     (pop_op),
        .o_pop_ready  (pop_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bin_index  (o_bin_index),
        .o_bin_count  (o_bin_count),
        .o_gaps_total (o_gaps_total),
        .o_last       (o_last)
    );

endmodule

// File: test/gap_length_histogram_tb.sv
`timescale 1ns / 1ps

module gap_length_histogram_tb;
    import glh_pkg::*;

    localparam int BINS          = 16;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [GAP_W-1:0] bin;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
        logic             last;
    } t_bin_report;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    t_cfg_index           i_cfg_index;
    logic [BOUND_W-1:0]   i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [15:0]          i_sample;
    logic                 i_last_of_stream;
    logic                 o_valid;
    logic                 i_ready;
    logic [GAP_W-1:0]     o_bin_index;
    logic [CNT_W-1:0]     o_bin_count;
    logic [CNT_W-1:0]     o_gaps_total;
    logic                 o_last;

    // predicted block state
    logic [BOUND_W-1:0] lo_edge  = LOWER_BOUND_RST;
    logic [BOUND_W-1:0] hi_edge  = UPPER_BOUND_RST;
    logic [GAP_W-1:0]   top_gap  = MAX_GAP_RST;
    logic [CNT_W-1:0]   gap_cap  = GAP_LIMIT_RST;
    logic [GAP_W-1:0]   run_len  = '0;
    logic [CNT_W-1:0]   gaps_recorded = '0;
    logic [CNT_W-1:0]   bin_tally [BINS];

    t_bin_report pending_bins [$];

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int mismatch_count = 0;
    int samples_sent   = 0;
    int reports_sent   = 0;
    int bins_checked   = 0;

    gap_length_histogram u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_last_of_stream (i_last_of_stream),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_bin_index      (o_bin_index),
        .o_bin_count      (o_bin_count),
        .o_gaps_total     (o_gaps_total),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d bin transfers outstanding", pending_bins.size());
        $display("FAIL gap_length_histogram");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic void clear_stream();
        run_len = '0;
        gaps_recorded = '0;
        foreach (bin_tally[i]) bin_tally[i] = '0;
    endfunction

    function automatic void apply_reg(t_cfg_index idx, logic [BOUND_W-1:0] data);
        case (idx)
            CFG_LOWER_BOUND: lo_edge = data;
            CFG_UPPER_BOUND: hi_edge = data;
            CFG_MAX_GAP:     top_gap = data[GAP_W-1:0];
            CFG_GAP_LIMIT:   gap_cap = data;
            default: ;
        endcase
    endfunction

    function automatic void predict_sample(logic [15:0] s, logic lst);
        int               top;
        int               b;
        t_bin_report      rep;
        top = (int'(top_gap) > BINS - 1) ? BINS - 1 : int'(top_gap);
        if (gaps_recorded < gap_cap) begin
            if (lo_edge <= s && s < hi_edge) begin
                b = (int'(run_len) < top) ? int'(run_len) : top;
                if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1'b1;
                if (gaps_recorded != '1) gaps_recorded = gaps_recorded + 1'b1;
                run_len = '0;
            end else if (run_len != '1) begin
                run_len = run_len + 1'b1;
            end
        end
        if (lst) begin
            for (b = 0; b <= top; b++) begin
                rep.bin   = GAP_W'(b);
                rep.count = bin_tally[b];
                rep.total = gaps_recorded;
                rep.last  = (b == top);
                pending_bins.insert(pending_bins.size(), rep);
            end
            reports_sent++;
            clear_stream();
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_bin();
        t_bin_report want;
        if (pending_bins.size() == 0) begin
            report_mismatch($sformatf("unexpected bin transfer bin=%0d count=%0d",
                                      o_bin_index, o_bin_count));
            return;
        end
        want = pending_bins.pop_front();
        bins_checked++;
        if (o_bin_index !== want.bin)
            report_mismatch($sformatf("bin_index got %0d want %0d", o_bin_index, want.bin));
        if (o_bin_count !== want.count)
            report_mismatch($sformatf("bin %0d count got %0d want %0d",
                                      want.bin, o_bin_count, want.count));
        if (o_gaps_total !== want.total)
            report_mismatch($sformatf("bin %0d gaps_total got %0d want %0d",
                                      want.bin, o_gaps_total, want.total));
        if (o_last !== want.last)
            report_mismatch($sformatf("bin %0d last got %0b want %0b",
                                      want.bin, o_last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) check_bin();
    end

    task automatic send_sample(input logic [15:0] s, input logic lst);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sample         <= s;
        i_last_of_stream <= lst;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_sample(s, lst);
        samples_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [BOUND_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] gap_word, input logic [15:0] lim);
        write_reg(CFG_LOWER_BOUND, lo);
        write_reg(CFG_UPPER_BOUND, hi);
        write_reg(CFG_MAX_GAP, gap_word);
        write_reg(CFG_GAP_LIMIT, lim);
    endtask

    function automatic logic [15:0] pick_miss();
        if (lo_edge >= hi_edge) return 16'($urandom);
        if (lo_edge != 0 && $urandom_range(1) == 0)
            return 16'($urandom_range(int'(lo_edge) - 1, 0));
        return 16'($urandom_range(65535, int'(hi_edge)));
    endfunction

    function automatic logic [15:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && lo_edge < hi_edge)
            return 16'($urandom_range(int'(hi_edge) - 1, int'(lo_edge)));
        if (roll < 70) return pick_miss();
        if (roll < 90) return 16'($urandom);
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return lo_edge;
            3: return lo_edge - 1'b1;
            4: return hi_edge;
            default: return hi_edge - 1'b1;
        endcase
    endfunction

    // default registers, both edges of the interval, then a report
    task automatic test_bounds_at_reset();
        send_sample(16'd19661, 1'b0);
        send_sample(16'd19660, 1'b0);
        send_sample(16'd39322, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd39321, 1'b0);
        send_sample(16'h0000, 1'b1);
    endtask

    // run counter saturates and lands in the top bin
    task automatic test_long_run();
        int i;
        settle();
        configure(16'd19661, 16'd39322, 16'hFFFF, 16'd1000);
        for (i = 0; i < 17; i++) send_sample(16'hFFFF, 1'b0);
        send_sample(16'd30000, 1'b1);
    endtask

    // single-bin report, samples past the limit change nothing
    task automatic test_limit_single_bin();
        settle();
        configure(16'd10000, 16'd30000, 16'hFFF0, 16'd2);
        send_sample(16'd20000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd20000, 1'b0);
        send_sample(16'd20000, 1'b1);
    endtask

    task automatic test_empty_and_zero_limit();
        settle();
        configure(16'hFFFF, 16'h0000, 16'd5, 16'd1000);
        send_sample(16'd30000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        settle();
        configure(16'h0000, 16'hFFFF, 16'd3, 16'd0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd100, 1'b1);
    endtask

    task automatic random_config();
        logic [15:0] a, b, lim;
        logic [3:0]  mg;
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(9))
            0: begin
                a = 16'h0000;
                b = 16'hFFFF;
            end
            1: ;
            2: b = a;
            default: if (a > b) {a, b} = {b, a};
        endcase
        case ($urandom_range(4))
            0: mg = 4'd0;
            1: mg = 4'd15;
            default: mg = 4'($urandom_range(15));
        endcase
        case ($urandom_range(7))
            0: lim = 16'($urandom_range(4));
            1: lim = 16'hFFFF;
            default: lim = 16'($urandom_range(65535, 40));
        endcase
        configure(a, b, {12'($urandom), mg}, lim);
    endtask

    task automatic test_random_streams(input int tx_pct, input int rx_pct, input int goal);
        int          set_idx;
        int          set_sent;
        int          burst;
        int          total;
        int          i;
        logic        first;
        logic [15:0] s;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (set_idx = 0; set_idx < 3; set_idx++) begin
            settle();
            random_config();
            set_sent = 0;
            first = 1'b1;
            while (set_sent < goal / 3) begin
                burst = ($urandom_range(4) == 0) ? $urandom_range(20, 14) : 0;
                total = burst + $urandom_range(12, 1);
                for (i = 0; i < total; i++) begin
                    s = (i < burst) ? pick_miss() : pick_sample();
                    send_sample(s, i == total - 1);
                end
                set_sent += total;
                // after the first report of each set, hold the sender until it is fully out
                if (first) begin
                    wait_drained();
                    first = 1'b0;
                end
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_LOWER_BOUND;
        i_cfg_data       <= '0;
        i_valid          <= 1'b0;
        i_sample         <= '0;
        i_last_of_stream <= 1'b0;
        clear_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct  = 33;
        rx_stall_pct = 86;
        test_bounds_at_reset();
        test_long_run();
        test_limit_single_bin();
        test_empty_and_zero_limit();
        test_random_streams(33, 86, 50);
        test_random_streams(86, 33, 50);
        test_random_streams(0, 0, 50);
        settle();

        $display("covered %0d sample transfers, %0d reports, %0d bin transfers checked",
                 samples_sent, reports_sent, bins_checked);
        $display("interval edges, empty interval, run saturation, gap limit, one-bin reports");
        if (mismatch_count == 0) begin
            $display("PASS gap_length_histogram");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL gap_length_histogram");
        end
        $finish;
    end

endmodule
